// ===== hdl/fqra_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fqra_pkg
// Shared types and constants for the queue with remove-at-position.
// ----------------------------------------------------------------------------
package fqra_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int DATA_W    = 32;
	localparam int POS_W     = 4;
	localparam int CNT_OUT_W = 5;

	typedef enum logic [1:0] {
		OP_ENQUEUE = 2'd0,
		OP_DEQUEUE = 2'd1,
		OP_REMOVE  = 2'd2,
		OP_QUERY   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ERR_OK       = 2'd0,
		ERR_FULL     = 2'd1,
		ERR_EMPTY    = 2'd2,
		ERR_POSITION = 2'd3
	} err_t;

	// per-cell update command
	typedef enum logic [1:0] {
		CELL_HOLD  = 2'd0,
		CELL_LOAD  = 2'd1,
		CELL_SHIFT = 2'd2
	} cell_cmd_t;

endpackage
`default_nettype wire

// ===== hdl/fqra_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fqra_cell
// One queue slot: holds, loads the enqueued value, or takes its right neighbor.
// ----------------------------------------------------------------------------
module fqra_cell
	import fqra_pkg::*;
(
	input  wire logic              clk,
	input  wire cell_cmd_t         cmd,
	input  wire logic [DATA_W-1:0] load_data,
	input  wire logic [DATA_W-1:0] next_data,
	output logic      [DATA_W-1:0] data
);

	logic [DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		case (cmd)
			CELL_LOAD:  data_q <= load_data;
			CELL_SHIFT: data_q <= next_data;
			default:    data_q <= data_q;
		endcase
	end

	assign data = data_q;

endmodule
`default_nettype wire

// ===== hdl/fifo_queue_with_remove_at_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_queue_with_remove_at_unit
// Bounded FIFO of signed 32-bit values with dequeue and remove-at-position.
// ----------------------------------------------------------------------------
// Result: the result strobe (done) is registered and rises in the cycle after start is taken.
// Throughput: one command per cycle; busy stays low, every cell of the row
//   updates in the same cycle the command is taken.
// Reset: arst_n clears the count and the result strobe; slot contents are
//   not reset and are only read below the count.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module fifo_queue_with_remove_at_unit
	import fqra_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic [1:0]              operation,
	input  wire logic signed [DATA_W-1:0] value,
	input  wire logic [POS_W-1:0]        position,
	output logic                         done,
	output logic signed [DATA_W-1:0]     head_value,
	output logic [CNT_OUT_W-1:0]         count,
	output logic                         is_empty,
	output logic [1:0]                   error_code
);

	// Count must reach DEPTH itself; compare width covers both count and position.
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	logic [CW-1:0] count_q;
	logic          done_q;
	err_t          err_s1;

	logic          xfer;
	op_t           op;
	logic          do_load;    // enqueue that fits
	logic          do_remove;  // dequeue or remove that hits a held entry
	logic [CMPW-1:0] rm_idx;   // slot whose entry leaves the row
	err_t          err_d;

	// Every command is taken at once; the row updates as the command is taken.
	assign busy = 1'b0;
	assign xfer = start & ~busy;
	assign op   = op_t'(operation);

	// Decode: which cells move and what error is reported.
	always_comb begin
		do_load   = 1'b0;
		do_remove = 1'b0;
		rm_idx    = '0;
		err_d     = ERR_OK;
		case (op)
			OP_ENQUEUE: begin
				if (count_q == CW'(DEPTH)) err_d = ERR_FULL;
				else                       do_load = 1'b1;
			end
			OP_DEQUEUE: begin
				if (count_q == '0) err_d = ERR_EMPTY;
				else               do_remove = 1'b1;
			end
			OP_REMOVE: begin
				rm_idx = CMPW'(position);
				if (CMPW'(position) >= CMPW'(count_q)) err_d = ERR_POSITION;
				else                                   do_remove = 1'b1;
			end
			default: begin
				// query leaves the queue as it is
			end
		endcase
	end

	// Row of cells, head in cell 0. A removal shifts every cell at or past the
	// gap one place toward the head; cells past the count take stale data,
	// which is never read.
	logic [DATA_W-1:0] cell_data [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cell_cmd_t         cmd;
		logic [DATA_W-1:0] nbr;

		if (i == DEPTH - 1) begin : g_last
			assign nbr = '0;
		end else begin : g_mid
			assign nbr = cell_data[i+1];
		end

		always_comb begin
			cmd = CELL_HOLD;
			if (xfer && do_load && (count_q == CW'(i)))
				cmd = CELL_LOAD;
			else if (xfer && do_remove && (CMPW'(i) >= rm_idx))
				cmd = CELL_SHIFT;
		end

		fqra_cell u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.load_data (value),
			.next_data (nbr),
			.data      (cell_data[i])
		);
	end

	// Count and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= xfer;
			if (xfer && do_load)
				count_q <= count_q + 1'b1;
			else if (xfer && do_remove)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (xfer) err_s1 <= err_d;
	end

	// Result transfer: the row already holds the post-command state.
	assign done       = done_q;
	assign is_empty   = (count_q == '0);
	assign head_value = is_empty ? '0 : cell_data[0];
	assign count      = CNT_OUT_W'(count_q);
	assign error_code = err_s1;

endmodule
`default_nettype wire

// ===== dv/fifo_queue_with_remove_at_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_queue_with_remove_at_unit_test
// Self-checking bench for the queue with remove-at-position. A directed run
// covers the empty and full corners, extreme values and every operation. A
// long random run follows, in fill, drain and mixed phases, with bursty
// command timing. Each result is checked against a shadow of the queue.
// ----------------------------------------------------------------------------
module fifo_queue_with_remove_at_unit_test;
	import fqra_pkg::*;

	localparam int CYCLE_LIMIT  = 100000;
	localparam int RANDOM_ITEMS = 650;

	// Expected status after one command.
	typedef struct {
		logic signed [DATA_W-1:0] head;
		logic [CNT_OUT_W-1:0]     cnt;
		logic                     empty;
		err_t                     err;
	} queue_status_t;

	// Shadow of the queue contents plus the statuses still owed by the block.
	class queue_scoreboard;
		logic signed [DATA_W-1:0] cells [DEPTH_DEF];
		int                       held;
		queue_status_t            owed[$];
		int                       fail_count;

		function new();
			held       = 0;
			fail_count = 0;
		endfunction

		// Apply one accepted command to the shadow, queue its status.
		function void note_command(op_t op, logic signed [DATA_W-1:0] val,
				logic [POS_W-1:0] pos);
			queue_status_t s;
			err_t          err;
			int            victim;
			err    = ERR_OK;
			victim = -1;
			case (op)
				OP_ENQUEUE: begin
					if (held >= DEPTH_DEF) begin
						err = ERR_FULL;
					end else begin
						cells[held] = val;
						held++;
					end
				end
				OP_DEQUEUE: begin
					if (held == 0) err = ERR_EMPTY;
					else victim = 0;
				end
				OP_REMOVE: begin
					if (int'(pos) >= held) err = ERR_POSITION;
					else victim = int'(pos);
				end
				default: ;
			endcase
			// later entries move up one place to close the gap
			if (victim >= 0) begin
				for (int i = victim; i + 1 < held; i++) cells[i] = cells[i + 1];
				held--;
			end
			s.head  = (held != 0) ? cells[0] : '0;
			s.cnt   = CNT_OUT_W'(held);
			s.empty = (held == 0);
			s.err   = err;
			owed.push_back(s);
		endfunction

		function void check_status(logic signed [DATA_W-1:0] head,
				logic [CNT_OUT_W-1:0] cnt, logic empty, logic [1:0] err);
			queue_status_t s;
			if (owed.size() == 0) begin
				$error("result with no command outstanding: head_value %0d count %0d",
					head, cnt);
				fail_count++;
				return;
			end
			s = owed.pop_front();
			if (head !== s.head) begin
				$error("head_value: expected %0d, got %0d", s.head, head);
				fail_count++;
			end
			if (cnt !== s.cnt) begin
				$error("count: expected %0d, got %0d", s.cnt, cnt);
				fail_count++;
			end
			if (empty !== s.empty) begin
				$error("is_empty: expected %0b, got %0b", s.empty, empty);
				fail_count++;
			end
			if (err !== s.err) begin
				$error("error_code: expected %0d, got %0d", s.err, err);
				fail_count++;
			end
		endfunction

		function void report_leftovers();
			if (owed.size() != 0) begin
				$error("%0d results never arrived", owed.size());
				fail_count++;
			end
		endfunction
	endclass

	logic                     clk        = 1'b0;
	logic                     arst_n     = 1'b0;
	logic                     start      = 1'b0;
	op_t                      operation  = OP_QUERY;
	logic signed [DATA_W-1:0] value      = '0;
	logic [POS_W-1:0]         position   = '0;
	logic                     busy;
	logic                     done;
	logic signed [DATA_W-1:0] head_value;
	logic [CNT_OUT_W-1:0]     count;
	logic                     is_empty;
	logic [1:0]               error_code;

	queue_scoreboard sb = new();
	int              cycle_count = 0;
	// Rough fill level seen by the stimulus, only used to aim positions.
	int              fill_guess  = 0;

	fifo_queue_with_remove_at_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.operation  (operation),
		.value      (value),
		.position   (position),
		.done       (done),
		.head_value (head_value),
		.count      (count),
		.is_empty   (is_empty),
		.error_code (error_code)
	);

	always #5 clk = ~clk;

	// Watchdog: a hung handshake or a lost strobe ends here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Monitor. Everything is sampled at the edge, before the driver's
	// nonblocking updates land, so input and result transfers are seen
	// exactly as the block sees them. A result strobe belongs to a command
	// taken on an earlier edge, so checking first keeps the order straight.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) sb.check_status(head_value, count, is_empty, error_code);
			if (start && !busy) sb.note_command(operation, value, position);
		end
	end

	// Present one command and hold it until the block takes it. start is
	// left high so a following command in the same burst goes back to back.
	task automatic send_command(input op_t op, input logic signed [DATA_W-1:0] val,
			input logic [POS_W-1:0] pos);
		start     <= 1'b1;
		operation <= op;
		value     <= val;
		position  <= pos;
		@(posedge clk);
		while (busy) @(posedge clk);
		case (op)
			OP_ENQUEUE: if (fill_guess < DEPTH_DEF) fill_guess++;
			OP_DEQUEUE: if (fill_guess > 0) fill_guess--;
			OP_REMOVE:  if (int'(pos) < fill_guess) fill_guess--;
			default: ;
		endcase
	endtask

	task automatic idle_for(input int cycles);
		if (cycles > 0) begin
			start <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// Sender backs off until every outstanding status has come back.
	task automatic hold_until_drained();
		start <= 1'b0;
		@(posedge clk);
		while (sb.owed.size() != 0) @(posedge clk);
	endtask

	initial begin
		logic signed [DATA_W-1:0] fill_val;
		op_t                      op;
		logic signed [DATA_W-1:0] val;
		logic [POS_W-1:0]         pos;
		int                       sent;
		int                       phase_left;
		int                       burst_left;
		int                       mode;
		int                       roll;
		bit                       quiet;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed: empty corners ---
		send_command(OP_QUERY, '0, '0);
		send_command(OP_DEQUEUE, '0, '0);        // dequeue on empty
		send_command(OP_REMOVE, '0, 4'd0);       // remove on empty, low position
		send_command(OP_REMOVE, '0, 4'd15);      // remove on empty, top position

		// --- directed: fill to the brim with extreme and toggling values ---
		for (int i = 0; i < DEPTH_DEF; i++) begin
			case (i)
				0:       fill_val = 32'sh8000_0000;
				1:       fill_val = 32'sh7FFF_FFFF;
				2:       fill_val = -32'sd1;
				3:       fill_val = 32'sd0;
				default: fill_val = (i % 2) ? (32'sh5555_5555 ^ i) : (32'shAAAA_AAAA ^ i);
			endcase
			send_command(OP_ENQUEUE, fill_val, POS_W'(i));
		end
		send_command(OP_ENQUEUE, 32'sh1234_5678, '0);  // enqueue on full
		send_command(OP_REMOVE, '0, 4'd15);   // drop the tail
		send_command(OP_REMOVE, '0, 4'd15);   // now one past the end
		send_command(OP_REMOVE, '0, 4'd7);    // drop from the middle
		send_command(OP_DEQUEUE, '0, '0);
		send_command(OP_QUERY, 32'shFFFF_FFFF, 4'd15);

		hold_until_drained();

		// --- random: phases biased toward filling, draining or a mix ---
		sent       = 0;
		phase_left = 0;
		burst_left = 0;
		quiet      = 1'b0;
		while (sent < RANDOM_ITEMS) begin
			if (phase_left == 0) begin
				phase_left = $urandom_range(10, 60);
				mode       = $urandom_range(0, 2);
				quiet      = ($urandom_range(0, 3) == 0);  // no gaps this phase
			end
			roll = $urandom_range(0, 99);
			case (mode)
				0:       op = (roll < 70) ? OP_ENQUEUE : (roll < 80) ? OP_DEQUEUE :
						(roll < 92) ? OP_REMOVE : OP_QUERY;
				1:       op = (roll < 15) ? OP_ENQUEUE : (roll < 50) ? OP_DEQUEUE :
						(roll < 90) ? OP_REMOVE : OP_QUERY;
				default: op = (roll < 35) ? OP_ENQUEUE : (roll < 60) ? OP_DEQUEUE :
						(roll < 90) ? OP_REMOVE : OP_QUERY;
			endcase
			// mostly in-range positions, with some anywhere in the field
			if (fill_guess > 0 && $urandom_range(0, 3) != 0)
				pos = POS_W'($urandom_range(0, fill_guess - 1));
			else
				pos = POS_W'($urandom_range(0, 15));
			case ($urandom_range(0, 15))
				0:       val = 32'sh8000_0000;
				1:       val = 32'sh7FFF_FFFF;
				2:       val = -32'sd1;
				3:       val = 32'sd0;
				default: val = $urandom;
			endcase

			send_command(op, val, pos);
			sent++;
			phase_left--;

			if (sent == RANDOM_ITEMS / 2) begin
				hold_until_drained();
			end else if (burst_left == 0) begin
				burst_left = $urandom_range(1, 16);
				if (!quiet) idle_for($urandom_range(1, 6));
			end else begin
				burst_left--;
			end
		end

		hold_until_drained();
		repeat (4) @(posedge clk);   // result strobe is registered, so it trails start
		sb.report_leftovers();

		if (sb.fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
